### rtl/core/lfs_pkg.sv
// Package for the line field selector: sizes, register indexes and the
// command and status structs that join the controller and the datapath.
// No dependencies.
package lfs_pkg;

  localparam int DATA_W     = 8;
  localparam int POS_W      = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int HOLD_DEPTH = 63;
  localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
  localparam int NUM_RANGES = 4;
  localparam int RANGE_REGS = 4;

  localparam logic [DATA_W-1:0] DEFAULT_DELIM = 8'h09;

  localparam logic [CFG_AW-1:0] REG_FIELD_MODE = 3'd0;
  localparam logic [CFG_AW-1:0] REG_DELIMITER  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SUPPRESS   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_RANGE_A    = 3'd3;

  typedef enum logic [1:0] {
    SEL_BYTE,
    SEL_DELIM,
    SEL_HOLD,
    SEL_DONE
  } out_sel_t;

  typedef struct packed {
    logic     cap_item;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
    logic     pos_bump;
    logic     hold_wr;
    logic     hold_clr;
    logic     ovf_set;
    logic     dseen_set;
    logic     any_set;
    logic     sep_set;
    logic     sep_clr;
    logic     line_clr;
    logic     flush_start;
    logic     flush_adv;
  } lfs_cmd_t;

  typedef struct packed {
    logic eol;
    logic field_mode;
    logic suppress;
    logic dseen;
    logic is_delim;
    logic sel_pos;
    logic sel_one;
    logic sep_pend;
    logic any_sent;
    logic hold_empty;
    logic hold_full;
    logic slot_free;
    logic flush_last;
  } lfs_stat_t;

endpackage

### rtl/core/line_field_selector.sv
// Top level of the line field selector: controller plus datapath.
// Uses lfs_pkg, lfs_ctrl, lfs_dp and (through lfs_dp) lfs_ram.
//
// The block selects columns or delimited fields from text lines. The in_
// channel carries one transaction per content byte and one per end of line
// (in_tuser high). The out_ channel carries result bytes; a result with
// out_tuser[0] set ends the output line. out_tlast marks the last result
// caused by one input transaction. Registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce. An accepted transaction
// is decoded in the next cycle; a result it makes directly is loaded into
// the output register from the decode step, and if that result ends the
// transaction, in_tready rises again as it is loaded. A flush of n held
// first-field bytes starts the read of the hold RAM's registered port in
// the decode step and then issues one byte per cycle while the output
// register is free, followed by the line-end result at end of line.
// Synchronous reset clears the line state and loads the register defaults;
// in_tready is low in reset and rises in the cycle after it. The hold RAM
// needs no clearing. When the receiver stalls, the output register holds
// its result and the controller waits before emitting more.
module line_field_selector
  import lfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic              in_tuser,   // [0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [7:0] out_byte
  output logic [1:0]        out_tuser,  // [0] line_done, [1] overflow
  output logic              out_tlast
);

  lfs_cmd_t  cmd;
  lfs_stat_t stat;

  lfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("Input accepted while a transaction was still in progress.");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("Line-end result is not the last result of its transaction.");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("Line-end result carries a non-zero byte.");

  a_flush_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush_adv |-> !stat.hold_empty && stat.field_mode)
    else $error("Hold flush running with an empty hold store.");

endmodule

### rtl/core/lfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lfs_ctrl.sv
// Controller of the line field selector: sequences one transaction through
// its result steps and the flush of held bytes. Uses lfs_pkg.
module lfs_ctrl
  import lfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  lfs_stat_t stat,
  output lfs_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SECOND,
    S_FLUSH,
    S_EOL
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;
  logic   sep_emit, byte_emit;

  assign in_tready = ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = SEL_BYTE;
    sep_emit  = stat.sep_pend && stat.sel_pos && stat.any_sent;
    byte_emit = !stat.is_delim && stat.sel_pos;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && ready_r) begin
          cmd.cap_item = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.eol) begin
          if (stat.field_mode && !stat.dseen && stat.suppress) begin
            cmd.line_clr = 1'b1;
            state_nxt    = S_IDLE;
          end else if (stat.field_mode && !stat.dseen && !stat.hold_empty) begin
            cmd.flush_start = 1'b1;
            state_nxt       = S_FLUSH;
          end else if (stat.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_DONE;
            cmd.out_last = 1'b1;
            cmd.line_clr = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (!stat.field_mode) begin
          if (!stat.sel_pos || stat.slot_free) begin
            cmd.out_load = stat.sel_pos;
            cmd.out_sel  = SEL_BYTE;
            cmd.out_last = 1'b1;
            cmd.pos_bump = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (!stat.dseen) begin
          if (stat.is_delim) begin
            cmd.dseen_set = 1'b1;
            cmd.pos_bump  = 1'b1;
            cmd.sep_set   = 1'b1;
            cmd.any_set   = stat.sel_one;
            if (stat.sel_one && !stat.hold_empty) begin
              cmd.flush_start = 1'b1;
              state_nxt       = S_FLUSH;
            end else begin
              cmd.hold_clr = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else begin
            cmd.hold_wr = !stat.hold_full;
            cmd.ovf_set = stat.hold_full;
            state_nxt   = S_IDLE;
          end
        end else if (!(sep_emit || byte_emit) || stat.slot_free) begin
          cmd.any_set  = stat.sep_pend && stat.sel_pos;
          cmd.sep_clr  = stat.sep_pend;
          cmd.pos_bump = stat.is_delim;
          cmd.sep_set  = stat.is_delim;
          state_nxt    = S_IDLE;
          if (sep_emit) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_DELIM;
            cmd.out_last = !byte_emit;
            if (byte_emit) begin
              state_nxt = S_SECOND;
            end
          end else if (byte_emit) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = SEL_BYTE;
            cmd.out_last = 1'b1;
          end
        end
      end
      S_SECOND: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_BYTE;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = SEL_HOLD;
          cmd.out_last  = !stat.eol && stat.flush_last;
          cmd.flush_adv = 1'b1;
          if (stat.flush_last) begin
            if (stat.eol) begin
              state_nxt = S_EOL;
            end else begin
              cmd.hold_clr = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end
      S_EOL: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = SEL_DONE;
          cmd.out_last = 1'b1;
          cmd.line_clr = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

### rtl/core/lfs_dp.sv
// Datapath of the line field selector: configuration registers, line state,
// range compare, hold store and the output register. Uses lfs_pkg and lfs_ram.
module lfs_dp
  import lfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic              in_tuser,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [DATA_W-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast,
  input  lfs_cmd_t          cmd,
  output lfs_stat_t         stat
);

  logic              mode_r, supp_r;
  logic [DATA_W-1:0] delim_r;
  logic [CFG_DW-1:0] range_r [NUM_RANGES];

  logic              item_eol_r;
  logic [DATA_W-1:0] item_byte_r;

  logic [HOLD_CW-1:0] hold_cnt_r, hold_cnt_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               dseen_r, dseen_nxt;
  logic               any_r, any_nxt;
  logic               sep_r, sep_nxt;
  logic               ovf_r, ovf_nxt;
  logic [HOLD_AW-1:0] fptr_r;

  logic              out_valid_r, out_done_r, out_ovf_r, out_last_r;
  logic [DATA_W-1:0] out_byte_r, out_byte_nxt;

  logic              sel_pos, sel_one, flush_last;
  logic              ram_re;
  logic [HOLD_AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      delim_r <= DEFAULT_DELIM;
      supp_r  <= 1'b0;
      for (int i = 0; i < NUM_RANGES; i++) begin
        range_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FIELD_MODE: mode_r  <= cfg_wdata[0];
        REG_DELIMITER:  delim_r <= cfg_wdata[DATA_W-1:0];
        REG_SUPPRESS:   supp_r  <= cfg_wdata[0];
        default: ;
      endcase
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (i < RANGE_REGS && cfg_addr == CFG_AW'(int'(REG_RANGE_A) + i)) begin
          range_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item_eol_r  <= in_tuser;
      item_byte_r <= in_tdata;
    end
  end

  always_comb begin
    sel_pos = 1'b0;
    sel_one = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (range_r[i][15:0] != '0) begin
        if (pos_r >= range_r[i][15:0] && pos_r <= range_r[i][31:16]) begin
          sel_pos = 1'b1;
        end
        if (range_r[i][15:0] == POS_W'(1) && range_r[i][31:16] != '0) begin
          sel_one = 1'b1;
        end
      end
    end
  end

  always_comb begin
    hold_cnt_nxt = hold_cnt_r;
    pos_nxt      = pos_r;
    dseen_nxt    = dseen_r;
    any_nxt      = any_r;
    sep_nxt      = sep_r;
    ovf_nxt      = ovf_r;
    if (cmd.hold_wr) begin
      hold_cnt_nxt = hold_cnt_r + HOLD_CW'(1);
    end
    if (cmd.hold_clr) begin
      hold_cnt_nxt = '0;
    end
    if (cmd.pos_bump && pos_r != '1) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (cmd.dseen_set) begin
      dseen_nxt = 1'b1;
    end
    if (cmd.any_set) begin
      any_nxt = 1'b1;
    end
    if (cmd.sep_clr) begin
      sep_nxt = 1'b0;
    end
    if (cmd.sep_set) begin
      sep_nxt = 1'b1;
    end
    if (cmd.ovf_set) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.line_clr) begin
      hold_cnt_nxt = '0;
      pos_nxt      = POS_W'(1);
      dseen_nxt    = 1'b0;
      any_nxt      = 1'b0;
      sep_nxt      = 1'b0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r <= '0;
      pos_r      <= POS_W'(1);
      dseen_r    <= 1'b0;
      any_r      <= 1'b0;
      sep_r      <= 1'b0;
      ovf_r      <= 1'b0;
    end else begin
      hold_cnt_r <= hold_cnt_nxt;
      pos_r      <= pos_nxt;
      dseen_r    <= dseen_nxt;
      any_r      <= any_nxt;
      sep_r      <= sep_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  assign flush_last = ((HOLD_CW + 1)'(fptr_r) + (HOLD_CW + 1)'(1)) == {1'b0, hold_cnt_r};
  assign ram_re     = cmd.flush_start || (cmd.flush_adv && !flush_last);
  assign ram_raddr  = cmd.flush_start ? '0 : fptr_r + HOLD_AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.flush_start) begin
      fptr_r <= '0;
    end else if (cmd.flush_adv) begin
      fptr_r <= fptr_r + HOLD_AW'(1);
    end
  end

  lfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold (
    .clk   (clk),
    .we    (cmd.hold_wr),
    .waddr (hold_cnt_r[HOLD_AW-1:0]),
    .wdata (item_byte_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (cmd.out_sel)
      SEL_BYTE:  out_byte_nxt = item_byte_r;
      SEL_DELIM: out_byte_nxt = delim_r;
      SEL_HOLD:  out_byte_nxt = ram_rdata;
      default:   out_byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_byte_r <= out_byte_nxt;
      out_done_r <= (cmd.out_sel == SEL_DONE);
      out_ovf_r  <= ovf_r;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_ovf_r, out_done_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    stat.eol        = item_eol_r;
    stat.field_mode = mode_r;
    stat.suppress   = supp_r;
    stat.dseen      = dseen_r;
    stat.is_delim   = (item_byte_r == delim_r);
    stat.sel_pos    = sel_pos;
    stat.sel_one    = sel_one;
    stat.sep_pend   = sep_r;
    stat.any_sent   = any_r;
    stat.hold_empty = (hold_cnt_r == '0);
    stat.hold_full  = (hold_cnt_r == HOLD_CW'(HOLD_DEPTH));
    stat.slot_free  = !out_valid_r || out_tready;
    stat.flush_last = flush_last;
  end

endmodule

### tb/tb_top.sv
// Self-checking testbench for line_field_selector: directed lines, then random
// lines under random register settings, compared with a line selection predictor.
// Depends on lfs_pkg and the line_field_selector RTL only.
`timescale 1ns / 1ps

module tb_top;
  import lfs_pkg::*;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOL  = 1'b1;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  localparam int RAND_ITEMS      = 130;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_SETTLE     = 8;
  localparam int CYCLE_LIMIT     = 4000000;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              done;
    logic              ovf;
    logic              last;
  } line_res_t;

  typedef struct {
    bit                is_reg;
    logic [CFG_AW-1:0] idx;
    logic [CFG_DW-1:0] val;
    logic              eol;
    logic [DATA_W-1:0] data;
    bit                typed;
    logic [DATA_W-1:0] r_byte;
    logic              r_done;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [7:0] in_byte
  logic              in_tuser;   // [0] req_type
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [7:0] out_byte
  logic [1:0]        out_tuser;  // [0] line_done, [1] overflow
  logic              out_tlast;

  // Predictor copy of the registers and the line state.
  logic              mode_r;
  logic [DATA_W-1:0] delim_r;
  logic              suppress_r;
  logic [CFG_DW-1:0] range_r [RANGE_REGS];
  logic [DATA_W-1:0] held [HOLD_DEPTH];
  int                held_cnt;
  logic [POS_W-1:0]  pos_r;
  bit                dseen;
  bit                any_sent;
  bit                sep_pend;
  bit                ovf_r;

  line_res_t sel_q[$];
  dir_row_t  dir_tab[$];
  int        errors;
  int        cycles;
  bit        tx_steady;
  logic      hold_req;

  line_field_selector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic bit pos_chosen(logic [POS_W-1:0] n);
    for (int k = 0; k < NUM_RANGES && k < RANGE_REGS; k++) begin
      if (range_r[k][15:0] != 16'd0 && n >= range_r[k][15:0] && n <= range_r[k][31:16])
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_sel(logic [DATA_W-1:0] b, logic done);
    line_res_t r;
    r.data = done ? '0 : b;
    r.done = done;
    r.ovf  = ovf_r;
    r.last = 1'b0;
    sel_q.push_back(r);
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_cnt; k++) push_sel(held[k], 1'b0);
  endfunction

  function automatic void bump_pos();
    if (pos_r < 16'hFFFF) pos_r++;
  endfunction

  function automatic void clear_line();
    held_cnt = 0;
    pos_r    = 16'd1;
    dseen    = 1'b0;
    any_sent = 1'b0;
    sep_pend = 1'b0;
    ovf_r    = 1'b0;
  endfunction

  // Works out the results of one accepted transaction; returns how many.
  function automatic int predict_item(logic eol, logic [DATA_W-1:0] b);
    int        n0;
    line_res_t r;
    n0 = sel_q.size();
    if (eol) begin
      if (mode_r && !dseen) begin
        if (!suppress_r) begin
          flush_held();
          push_sel('0, 1'b1);
        end
      end else begin
        push_sel('0, 1'b1);
      end
      clear_line();
    end else if (!mode_r) begin
      if (pos_chosen(pos_r)) push_sel(b, 1'b0);
      bump_pos();
    end else if (!dseen) begin
      if (b == delim_r) begin
        if (pos_chosen(16'd1)) begin
          flush_held();
          any_sent = 1'b1;
        end
        dseen    = 1'b1;
        held_cnt = 0;
        bump_pos();
        sep_pend = 1'b1;
      end else if (held_cnt < HOLD_DEPTH) begin
        held[held_cnt] = b;
        held_cnt++;
      end else begin
        ovf_r = 1'b1;
      end
    end else begin
      if (sep_pend) begin
        if (pos_chosen(pos_r)) begin
          if (any_sent) push_sel(delim_r, 1'b0);
          any_sent = 1'b1;
        end
        sep_pend = 1'b0;
      end
      if (b == delim_r) begin
        bump_pos();
        sep_pend = 1'b1;
      end else if (pos_chosen(pos_r)) begin
        push_sel(b, 1'b0);
      end
    end
    if (sel_q.size() > n0) begin
      r = sel_q.pop_back();
      r.last = 1'b1;
      sel_q.push_back(r);
    end
    return sel_q.size() - n0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DW-1:0] pick_range();
    logic [15:0] lo;
    lo = 16'($urandom_range(1, 4));
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {16'(lo + 16'($urandom_range(0, 3))), lo};
      2:       return 32'hFFFF_0001;
      3:       return $urandom;
      4:       return {16'(lo - 16'd1), lo};
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  function automatic dir_row_t item_row(logic eol, logic [DATA_W-1:0] b, bit typed,
                                        logic [DATA_W-1:0] r_byte, logic r_done);
    dir_row_t row;
    row = '{default: '0};
    row.eol    = eol;
    row.data   = b;
    row.typed  = typed;
    row.r_byte = r_byte;
    row.r_done = r_done;
    return row;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    errors++;
    if (errors <= 200)
      $display("[%0t] mismatch in %s: got 'h%0h, want 'h%0h", $time, what, got, want);
  endtask

  // The register write is left asserted; the caller lowers cfg_we after a batch.
  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_FIELD_MODE: mode_r = val[0];
      REG_DELIMITER:  delim_r = val[7:0];
      REG_SUPPRESS:   suppress_r = val[0];
      default: begin
        if (int'(idx) >= int'(REG_RANGE_A) && int'(idx) < int'(REG_RANGE_A) + RANGE_REGS)
          range_r[int'(idx) - int'(REG_RANGE_A)] = val;
      end
    endcase
  endtask

  task automatic send_item(logic eol, logic [DATA_W-1:0] b, output int n_res);
    int unsigned gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eol;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_res = predict_item(eol, b);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sel_q.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  always @(posedge clk) begin
    line_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sel_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_tdata, 8'h00);
      end else begin
        want = sel_q.pop_front();
        if (!want.done && out_tdata !== want.data)
          report_mismatch("out_byte", out_tdata, want.data);
        if (out_tuser[0] !== want.done)
          report_mismatch("line_done", 8'(out_tuser[0]), 8'(want.done));
        if (out_tuser[1] !== want.ovf)
          report_mismatch("overflow", 8'(out_tuser[1]), 8'(want.ovf));
        if (out_tlast !== want.last)
          report_mismatch("last_of_run", 8'(out_tlast), 8'(want.last));
      end
    end
  end

  // Receiver: random stalls, calm stretches, and one long hold-off on request.
  initial begin : rx_proc
    int unsigned stall;
    int unsigned calm_left;
    bit          hold_used;
    stall      = 0;
    calm_left  = 0;
    hold_used  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        stall     = HOLD_OFF_CYCLES;
      end else if (stall > 0) begin
        stall--;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm_left = $urandom_range(50, 150);
      end else begin
        stall = pick_gap();
      end
      out_tready <= (stall == 0);
    end
  end

  initial begin
    int                n_res;
    bit                prev_reg;
    int                rand_items;
    int                ph;
    int                n_lines;
    int unsigned       head;
    int unsigned       len;
    bit                long_line;
    logic              mode;
    logic [DATA_W-1:0] d;
    logic [DATA_W-1:0] b;
    logic [CFG_DW-1:0] rng [RANGE_REGS];
    line_res_t         r;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    hold_req  = 1'b0;
    tx_steady = 1'b0;
    errors    = 0;
    cycles    = 0;

    mode_r     = 1'b0;
    delim_r    = DEFAULT_DELIM;
    suppress_r = 1'b0;
    foreach (range_r[k]) range_r[k] = '0;
    foreach (held[k]) held[k] = '0;
    clear_line();

    // Character mode straight after reset selects nothing: only line ends.
    dir_tab.push_back(item_row(REQ_BYTE, 8'h41, 0, 8'h00, 1'b0));
    dir_tab.push_back(item_row(REQ_EOL,  8'h00, 1, 8'h00, 1'b1));
    dir_tab.push_back(item_row(REQ_EOL,  8'hFF, 1, 8'h00, 1'b1));
    dir_tab.push_back(reg_row(REG_RANGE_A, 32'hFFFF_0001));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h00, 1, 8'h00, 1'b0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'hFF, 1, 8'hFF, 1'b0));
    dir_tab.push_back(item_row(REQ_EOL,  8'h5A, 1, 8'h00, 1'b1));
    dir_tab.push_back(reg_row(REG_RANGE_A,        {16'd3, 16'd2}));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd1, {16'd1, 16'd4}));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd2, {16'hFFFF, 16'd0}));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd3, {16'd6, 16'd6}));
    for (int k = 0; k < 6; k++) dir_tab.push_back(item_row(REQ_BYTE, 8'h61 + 8'(k), 0, 0, 0));
    dir_tab.push_back(item_row(REQ_EOL, 8'h00, 0, 8'h00, 1'b0));
    // Field mode: an empty middle field keeps its separator, a trailing one is dropped.
    dir_tab.push_back(reg_row(REG_FIELD_MODE, 32'd1));
    dir_tab.push_back(reg_row(REG_DELIMITER, 32'h2C));
    dir_tab.push_back(reg_row(REG_RANGE_A,        {16'd2, 16'd1}));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd1, {16'd4, 16'd4}));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd2, 32'd0));
    dir_tab.push_back(reg_row(REG_RANGE_A + 3'd3, 32'd0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h78, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h2C, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h2C, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h7A, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h2C, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_EOL,  8'h00, 0, 0, 0));
    // A line without the delimiter passes whole, or vanishes when suppressed.
    dir_tab.push_back(item_row(REQ_BYTE, 8'h70, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_EOL,  8'h00, 0, 0, 0));
    dir_tab.push_back(reg_row(REG_SUPPRESS, 32'd1));
    dir_tab.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
    dir_tab.push_back(item_row(REQ_BYTE, 8'h71, 0, 0, 0));
    dir_tab.push_back(item_row(REQ_EOL,  8'h00, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_reg) begin
        if (!prev_reg) wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        send_item(dir_tab[i].eol, dir_tab[i].data, n_res);
        if (dir_tab[i].typed) begin
          repeat (n_res) void'(sel_q.pop_back());
          r.data = dir_tab[i].r_byte;
          r.done = dir_tab[i].r_done;
          r.ovf  = 1'b0;
          r.last = 1'b1;
          sel_q.push_back(r);
        end
      end
      prev_reg = dir_tab[i].is_reg;
    end

    rand_items = 0;
    ph = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      mode = (ph == 0) ? 1'b1 : (ph == 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 4))
        0:       d = DEFAULT_DELIM;
        1:       d = 8'h2C;
        2:       d = 8'h00;
        3:       d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      foreach (rng[k]) rng[k] = pick_range();
      if (ph == 1) rng[0] = 32'hFFFF_0001;
      write_reg(REG_FIELD_MODE, 32'(mode));
      write_reg(REG_DELIMITER, 32'(d));
      write_reg(REG_SUPPRESS, 32'($urandom_range(0, 1)));
      for (int k = 0; k < RANGE_REGS; k++) write_reg(REG_RANGE_A + 3'(k), rng[k]);
      cfg_we <= 1'b0;
      if (ph == 1) hold_req <= 1'b1;
      tx_steady = (ph % 3 == 2);
      n_lines = $urandom_range(2, 4);
      for (int ln = 0; ln < n_lines; ln++) begin
        long_line = (ph == 0 && ln == 0) || ($urandom_range(0, 9) == 0);
        head = (ph == 0 && ln == 0) ? $urandom_range(64, 68) :
               long_line ? $urandom_range(60, 68) : 0;
        len  = long_line ? $urandom_range(0, 6) : $urandom_range(0, 12);
        for (int k = 0; k < head; k++) begin
          b = 8'($urandom);
          if (b == d) b = b ^ 8'h01;
          send_item(REQ_BYTE, b, n_res);
        end
        for (int k = 0; k < len; k++) begin
          b = ($urandom_range(0, 3) == 0) ? d : 8'($urandom);
          send_item(REQ_BYTE, b, n_res);
        end
        rand_items += head + len;
        // Some phases end inside a line, so the next settings apply mid-line.
        if (ln < n_lines - 1 || (ph != 1 && $urandom_range(0, 9) != 0)) begin
          send_item(REQ_EOL, 8'($urandom), n_res);
          rand_items++;
        end
      end
      ph++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/lfs_pkg.sv
rtl/core/lfs_ram.sv
rtl/core/lfs_ctrl.sv
rtl/core/lfs_dp.sv
rtl/core/line_field_selector.sv
tb/tb_top.sv
